### rtl/priority_range_load_shed_defines.svh
// Assertion macros shared by the load-shed classifier RTL.
// Plain text macros only; included by the modules that carry checks.
`ifndef PRIORITY_RANGE_LOAD_SHED_DEFINES_SVH
`define PRIORITY_RANGE_LOAD_SHED_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PRLS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define PRLS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`define PRLS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define PRLS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PRLS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`define PRLS_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### rtl/prls_pkg.sv
// Package for the priority range load-shed classifier.
// Holds field widths, parameter defaults, verdict, command and state codes.
package prls_pkg;

  localparam int unsigned TABLE_SLOTS_DEF   = 8;
  localparam int unsigned SHED_POINTS_DEF   = 8;
  localparam int unsigned PRIORITY_BITS_DEF = 31;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned IDX_W        = 3;
  localparam int unsigned POINT_W      = 3;
  localparam int unsigned FLAGS_W      = 8;
  localparam int unsigned PRIO_PORT_W  = 31;
  localparam int unsigned VERDICT_W    = 3;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 3;
  localparam int unsigned NUM_COUNTERS = 6;

  localparam int unsigned CNT_TOTAL     = 0;
  localparam int unsigned CNT_MISSING   = 1;
  localparam int unsigned CNT_INVALID   = 2;
  localparam int unsigned CNT_UNMATCHED = 3;
  localparam int unsigned CNT_PASSED    = 4;
  localparam int unsigned CNT_SHED      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ENABLED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_POINT   = CFG_IDX_W'(1);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS      = 3'd0,
    VERDICT_SHED      = 3'd1,
    VERDICT_MISSING   = 3'd2,
    VERDICT_INVALID   = 3'd3,
    VERDICT_UNMATCHED = 3'd4,
    VERDICT_WRITE_OK  = 3'd5,
    VERDICT_REFUSED   = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_INSTALL,
    CMD_REFUSE,
    CMD_LOOKUP,
    CMD_MISSING,
    CMD_INVALID
  } cmd_kind_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_e;

endpackage

### rtl/priority_range_load_shed.sv
// Top level of the priority range load-shed classifier.
// Depends on prls_pkg, prls_front, prls_queue and prls_back.
//
// Input channel (in_valid_i / in_stall_o) carries either a range table write
// (req_type_i low) or a request to classify (req_type_i high). The output
// channel (out_valid_o / out_stall_i) returns exactly one result per input
// transaction, in order. The configuration channel (cfg_valid_i / cfg_ready_o)
// sets the default point enable (index 0) and default point (index 1); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. Accepted transactions enter a two-entry
// queue. A lookup or an install scans the whole table through the single read
// port of the slot RAM; a clear, a write refused by the front end or a
// request without a usable header skips the scan. The result is visible the
// cycle after it is finished. While the receiver stalls, the result is held,
// the back end waits with the next result finished, and the queue fills until
// in_stall_o rises. Reset empties the table, zeroes the six event counters
// and disables the default point; no clearing pass is needed.
module priority_range_load_shed
  #(
  parameter int unsigned TABLE_SLOTS   = prls_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned SHED_POINTS   = prls_pkg::SHED_POINTS_DEF,
  parameter int unsigned PRIORITY_BITS = prls_pkg::PRIORITY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [prls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prls_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [prls_pkg::IDX_W-1:0]       entry_index_i,
  input  logic                             entry_valid_i,
  input  logic [prls_pkg::PRIO_PORT_W-1:0] range_start_i,
  input  logic [prls_pkg::PRIO_PORT_W-1:0] range_end_i,
  input  logic [prls_pkg::POINT_W-1:0]     entry_point_i,
  input  logic                             header_present_i,
  input  logic                             header_valid_i,
  input  logic [prls_pkg::PRIO_PORT_W-1:0] priority_value_i,
  input  logic [prls_pkg::FLAGS_W-1:0]     shed_flags_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [prls_pkg::VERDICT_W-1:0]   verdict_o,
  output logic [prls_pkg::POINT_W-1:0]     point_used_o,
  output logic                             used_default_o,
  output logic [prls_pkg::IDX_W-1:0]       matched_slot_o,
  output logic [prls_pkg::COUNT_W-1:0]     request_count_o
);
  import prls_pkg::*;

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // For a request, lo carries the priority value and hi is unused.
  typedef struct packed {
    cmd_kind_e                kind;
    logic [SLOT_W-1:0]        idx;
    logic [PRIORITY_BITS-1:0] lo;
    logic [PRIORITY_BITS-1:0] hi;
    logic [POINT_W-1:0]       point;
    logic [FLAGS_W-1:0]       flags;
  } cmd_t;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  prls_front #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .SHED_POINTS  (SHED_POINTS),
    .PRIORITY_BITS(PRIORITY_BITS),
    .cmd_t        (cmd_t)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .entry_valid_i   (entry_valid_i),
    .range_start_i   (range_start_i),
    .range_end_i     (range_end_i),
    .entry_point_i   (entry_point_i),
    .header_present_i(header_present_i),
    .header_valid_i  (header_valid_i),
    .priority_value_i(priority_value_i),
    .shed_flags_i    (shed_flags_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  prls_queue #(
    .DEPTH (QUEUE_DEPTH),
    .item_t(cmd_t)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (head_cmd)
  );

  prls_back #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .SHED_POINTS  (SHED_POINTS),
    .PRIORITY_BITS(PRIORITY_BITS),
    .cmd_t        (cmd_t)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_valid_i      (q_valid),
    .q_cmd_i        (head_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .point_used_o   (point_used_o),
    .used_default_o (used_default_o),
    .matched_slot_o (matched_slot_o),
    .request_count_o(request_count_o)
  );

endmodule

### rtl/prls_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on prls_pkg for default sizes only.
module prls_ram #(
  parameter int unsigned WIDTH = 2 * prls_pkg::PRIORITY_BITS_DEF + prls_pkg::POINT_W,
  parameter int unsigned DEPTH = prls_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/prls_front.sv
// Front end: takes input transactions and classifies them into commands.
// Depends on prls_pkg; the command struct type is handed in from the top level.
module prls_front #(
  parameter int unsigned TABLE_SLOTS   = prls_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned SHED_POINTS   = prls_pkg::SHED_POINTS_DEF,
  parameter int unsigned PRIORITY_BITS = prls_pkg::PRIORITY_BITS_DEF,
  parameter type         cmd_t         = logic
) (
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [prls_pkg::IDX_W-1:0]       entry_index_i,
  input  logic                             entry_valid_i,
  input  logic [prls_pkg::PRIO_PORT_W-1:0] range_start_i,
  input  logic [prls_pkg::PRIO_PORT_W-1:0] range_end_i,
  input  logic [prls_pkg::POINT_W-1:0]     entry_point_i,
  input  logic                             header_present_i,
  input  logic                             header_valid_i,
  input  logic [prls_pkg::PRIO_PORT_W-1:0] priority_value_i,
  input  logic [prls_pkg::FLAGS_W-1:0]     shed_flags_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output cmd_t                             q_cmd_o
);
  import prls_pkg::*;

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [PRIORITY_BITS-1:0] lo;
  logic [PRIORITY_BITS-1:0] hi;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign lo = range_start_i[PRIORITY_BITS-1:0];
  assign hi = range_end_i[PRIORITY_BITS-1:0];

  // Everything that needs no table access is settled here, so the back end
  // only scans for lookups and for installs that must be checked for overlap.
  always_comb begin
    q_cmd_o.idx   = SLOT_W'(entry_index_i);
    q_cmd_o.lo    = lo;
    q_cmd_o.hi    = hi;
    q_cmd_o.point = entry_point_i;
    q_cmd_o.flags = shed_flags_i;
    if (req_type_i) begin
      q_cmd_o.lo = priority_value_i[PRIORITY_BITS-1:0];
      q_cmd_o.hi = '0;
      if (!header_present_i) begin
        q_cmd_o.kind = CMD_MISSING;
      end else if (!header_valid_i) begin
        q_cmd_o.kind = CMD_INVALID;
      end else begin
        q_cmd_o.kind = CMD_LOOKUP;
      end
    end else begin
      if (32'(entry_index_i) >= TABLE_SLOTS) begin
        q_cmd_o.kind = CMD_REFUSE;
      end else if (!entry_valid_i) begin
        q_cmd_o.kind = CMD_CLEAR;
      end else if (lo >= hi || 32'(entry_point_i) >= SHED_POINTS) begin
        q_cmd_o.kind = CMD_REFUSE;
      end else begin
        q_cmd_o.kind = CMD_INSTALL;
      end
    end
  end

endmodule

### rtl/prls_queue.sv
// Short command queue between the classifier front end and the back end.
// Depends on prls_pkg for its default depth; includes the assertion macros.
`include "priority_range_load_shed_defines.svh"

module prls_queue #(
  parameter int unsigned DEPTH  = prls_pkg::QUEUE_DEPTH,
  parameter type         item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == FULL_CNT);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `PRLS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT)
  `PRLS_ASSERT_IMP(a_empty_ptrs, clk_i, rst_ni, count_q == '0, rd_ptr_q == wr_ptr_q)
  `PRLS_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0)
  `PRLS_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, pop_i && !push_i, count_q == $past(count_q) - CNT_W'(1))

endmodule

### rtl/prls_back.sv
// Back end: scans the range table, installs and clears slots, keeps the event
// counters and the output register. Depends on prls_pkg, prls_ram and the macros.
`include "priority_range_load_shed_defines.svh"

module prls_back #(
  parameter int unsigned TABLE_SLOTS   = prls_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned SHED_POINTS   = prls_pkg::SHED_POINTS_DEF,
  parameter int unsigned PRIORITY_BITS = prls_pkg::PRIORITY_BITS_DEF,
  parameter type         cmd_t         = logic
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prls_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prls_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            q_valid_i,
  input  cmd_t                            q_cmd_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [prls_pkg::VERDICT_W-1:0]  verdict_o,
  output logic [prls_pkg::POINT_W-1:0]    point_used_o,
  output logic                            used_default_o,
  output logic [prls_pkg::IDX_W-1:0]      matched_slot_o,
  output logic [prls_pkg::COUNT_W-1:0]    request_count_o
);
  import prls_pkg::*;

  localparam int unsigned SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned STEP_W  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W = 2 * PRIORITY_BITS + POINT_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_SLOTS);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               chk_q, chk_d;
  logic [SLOT_W-1:0]  chk_idx_q, chk_idx_d;
  logic               hit_q, hit_d;
  logic [SLOT_W-1:0]  hit_slot_q, hit_slot_d;
  logic [POINT_W-1:0] hit_point_q, hit_point_d;
  logic               overlap_q, overlap_d;
  logic [TABLE_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic               dflt_en_q;
  logic [POINT_W-1:0] dflt_pt_q;
  logic [COUNT_W-1:0] cnt_q [NUM_COUNTERS];
  logic [COUNT_W-1:0] cnt_nxt [NUM_COUNTERS];

  logic               out_valid_q;
  verdict_e           verdict_q;
  logic [POINT_W-1:0] point_used_q;
  logic               used_default_q;
  logic [IDX_W-1:0]   matched_slot_q;
  logic [COUNT_W-1:0] request_count_q;

  logic                     fire;
  logic                     ram_we;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [PRIORITY_BITS-1:0] ent_start;
  logic [PRIORITY_BITS-1:0] ent_end;
  logic [POINT_W-1:0]       ent_point;
  logic                     ent_ok;
  logic                     ent_match;
  logic                     ent_overlap;

  verdict_e           res_verdict;
  verdict_e           miss_verdict;
  logic [POINT_W-1:0] res_point;
  logic [POINT_W-1:0] sel_point;
  logic               res_default;
  logic [SLOT_W-1:0]  res_slot;
  logic [NUM_COUNTERS-1:0] bump;
  logic               have_pt;
  logic               shed;
  logic               clear_slot;
  logic               install;

  assign cfg_ready_o = 1'b1;

  // Results leave through one register, so the back end finishes an item
  // only once that register is empty or being taken.
  assign fire = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  prls_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_q.idx),
    .wdata_i({cmd_q.lo, cmd_q.hi, cmd_q.point}),
    .raddr_i(step_q[SLOT_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign ent_start = ram_rdata[ENTRY_W-1 -: PRIORITY_BITS];
  assign ent_end   = ram_rdata[POINT_W +: PRIORITY_BITS];
  assign ent_point = ram_rdata[POINT_W-1:0];

  assign ent_ok      = chk_q && slot_valid_q[chk_idx_q];
  assign ent_match   = ent_ok && (cmd_q.kind == CMD_LOOKUP) &&
                       (ent_start <= cmd_q.lo) && (cmd_q.lo < ent_end);
  assign ent_overlap = ent_ok && (cmd_q.kind == CMD_INSTALL) && (chk_idx_q != cmd_q.idx) &&
                       (cmd_q.lo < ent_end) && (ent_start < cmd_q.hi);

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.kind == CMD_LOOKUP || q_cmd_i.kind == CMD_INSTALL) begin
            state_d = B_SCAN;
          end else begin
            state_d = B_DONE;
          end
        end
      end
      B_SCAN: begin
        if (step_q == LAST_STEP) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (fire) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // The RAM read is registered, so slot k is compared in the cycle after its
  // address was issued; the scan runs one step past the last slot.
  always_comb begin : scan_control
    q_pop_o     = 1'b0;
    cmd_d       = cmd_q;
    step_d      = step_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_point_d = hit_point_q;
    overlap_d   = overlap_q;
    unique case (state_q)
      B_IDLE: begin
        q_pop_o     = q_valid_i;
        cmd_d       = q_cmd_i;
        step_d      = '0;
        hit_d       = 1'b0;
        hit_slot_d  = '0;
        hit_point_d = '0;
        overlap_d   = 1'b0;
      end
      B_SCAN: begin
        if (step_q != LAST_STEP) begin
          step_d = step_q + STEP_W'(1);
        end
        chk_d     = (step_q < LAST_STEP);
        chk_idx_d = step_q[SLOT_W-1:0];
        if (ent_match && !hit_q) begin
          hit_d       = 1'b1;
          hit_slot_d  = chk_idx_q;
          hit_point_d = ent_point;
        end
        if (ent_overlap) begin
          overlap_d = 1'b1;
        end
      end
      B_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin : result
    res_verdict  = VERDICT_WRITE_OK;
    miss_verdict = VERDICT_UNMATCHED;
    res_point    = '0;
    sel_point    = '0;
    res_default  = 1'b0;
    res_slot     = '0;
    bump         = '0;
    have_pt      = 1'b0;
    shed         = 1'b0;
    clear_slot   = 1'b0;
    install      = 1'b0;
    unique case (cmd_q.kind) inside
      CMD_CLEAR: begin
        clear_slot = 1'b1;
      end
      CMD_REFUSE: begin
        res_verdict = VERDICT_REFUSED;
      end
      CMD_INSTALL: begin
        if (overlap_q) begin
          res_verdict = VERDICT_REFUSED;
        end else begin
          install = 1'b1;
        end
      end
      CMD_LOOKUP, CMD_MISSING, CMD_INVALID: begin
        bump[CNT_TOTAL] = 1'b1;
        if (cmd_q.kind == CMD_MISSING) begin
          bump[CNT_MISSING] = 1'b1;
          miss_verdict      = VERDICT_MISSING;
        end else if (cmd_q.kind == CMD_INVALID) begin
          bump[CNT_INVALID] = 1'b1;
          miss_verdict      = VERDICT_INVALID;
        end else if (hit_q) begin
          have_pt   = 1'b1;
          sel_point = hit_point_q;
          res_slot  = hit_slot_q;
        end else begin
          bump[CNT_UNMATCHED] = 1'b1;
        end
        if (!have_pt && dflt_en_q) begin
          have_pt     = 1'b1;
          sel_point   = dflt_pt_q;
          res_default = 1'b1;
        end
        if (have_pt) begin
          // A point beyond the configured number never sheds.
          shed      = (32'(sel_point) < SHED_POINTS) && cmd_q.flags[sel_point];
          res_point = sel_point;
          if (shed) begin
            bump[CNT_SHED] = 1'b1;
            res_verdict    = VERDICT_SHED;
          end else begin
            bump[CNT_PASSED] = 1'b1;
            res_verdict      = VERDICT_PASS;
          end
        end else begin
          res_verdict = miss_verdict;
        end
      end
      default: begin
        res_verdict = VERDICT_REFUSED;
      end
    endcase
  end

  assign ram_we = fire && install;

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (fire && clear_slot) begin
      slot_valid_d[cmd_q.idx] = 1'b0;
    end
    if (ram_we) begin
      slot_valid_d[cmd_q.idx] = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (fire && bump[i] && (cnt_q[i] != {COUNT_W{1'b1}})) begin
        cnt_nxt[i] = cnt_q[i] + COUNT_W'(1);
      end else begin
        cnt_nxt[i] = cnt_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      step_q       <= '0;
      chk_q        <= 1'b0;
      hit_q        <= 1'b0;
      overlap_q    <= 1'b0;
      slot_valid_q <= '0;
      dflt_en_q    <= 1'b0;
      dflt_pt_q    <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      chk_q        <= chk_d;
      hit_q        <= hit_d;
      overlap_q    <= overlap_d;
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= fire || (out_valid_q && out_stall_i);
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_q[i] <= cnt_nxt[i];
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DEFAULT_ENABLED: dflt_en_q <= cfg_data_i[0];
          CFG_DEFAULT_POINT:   dflt_pt_q <= cfg_data_i[POINT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    chk_idx_q   <= chk_idx_d;
    hit_slot_q  <= hit_slot_d;
    hit_point_q <= hit_point_d;
    if (fire) begin
      verdict_q       <= res_verdict;
      point_used_q    <= res_point;
      used_default_q  <= res_default;
      matched_slot_q  <= IDX_W'(res_slot);
      request_count_q <= cnt_nxt[CNT_TOTAL];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign point_used_o    = point_used_q;
  assign used_default_o  = used_default_q;
  assign matched_slot_o  = matched_slot_q;
  assign request_count_o = request_count_q;

  `PRLS_ASSERT_IMP(a_step_bound, clk_i, rst_ni, state_q == B_SCAN, step_q <= LAST_STEP)
  `PRLS_ASSERT_IMP(a_check_in_scan, clk_i, rst_ni, chk_q, state_q == B_SCAN)
  `PRLS_ASSERT_NXT(a_result_held, clk_i, rst_ni, fire, out_valid_q)
  `PRLS_ASSERT_NXT(a_count_shown, clk_i, rst_ni, fire, request_count_q == cnt_q[CNT_TOTAL])

endmodule

### verif/tb.sv
// Self-checking testbench for the priority range load-shed classifier.
// Depends on prls_pkg and priority_range_load_shed; drives both channels with
// random idling and checks every result against an in-bench predictor.
module tb;
  import prls_pkg::*;

  localparam int unsigned SLOTS          = TABLE_SLOTS_DEF;
  localparam int unsigned POINTS         = SHED_POINTS_DEF;
  localparam int unsigned PBITS          = PRIORITY_BITS_DEF;
  localparam logic [PRIO_PORT_W-1:0] PRIO_MASK = PRIO_PORT_W'((64'd1 << PBITS) - 1);
  localparam logic [PRIO_PORT_W-1:0] PRIO_MAX  = '1;
  localparam int unsigned LOCAL_SPAN     = 4096;
  localparam int unsigned SEGMENT_ITEMS  = 225;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [IDX_W-1:0]       entry_index;
    logic                   entry_valid;
    logic [PRIO_PORT_W-1:0] range_start;
    logic [PRIO_PORT_W-1:0] range_end;
    logic [POINT_W-1:0]     entry_point;
    logic                   header_present;
    logic                   header_valid;
    logic [PRIO_PORT_W-1:0] priority_value;
    logic [FLAGS_W-1:0]     shed_flags;
  } shed_item_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [POINT_W-1:0] point_used;
    logic               used_default;
    logic [IDX_W-1:0]   matched_slot;
    logic [COUNT_W-1:0] request_count;
  } shed_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   req_type_i;
  logic [IDX_W-1:0]       entry_index_i;
  logic                   entry_valid_i;
  logic [PRIO_PORT_W-1:0] range_start_i;
  logic [PRIO_PORT_W-1:0] range_end_i;
  logic [POINT_W-1:0]     entry_point_i;
  logic                   header_present_i;
  logic                   header_valid_i;
  logic [PRIO_PORT_W-1:0] priority_value_i;
  logic [FLAGS_W-1:0]     shed_flags_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [VERDICT_W-1:0]   verdict_o;
  logic [POINT_W-1:0]     point_used_o;
  logic                   used_default_o;
  logic [IDX_W-1:0]       matched_slot_o;
  logic [COUNT_W-1:0]     request_count_o;

  shed_item_t   drv_item = '0;
  shed_item_t   pending_items[$];
  shed_result_t expected_results[$];
  shed_result_t oldest_result;
  logic         in_fire = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;
  int unsigned  n_pushed      = 0;
  int unsigned  n_accepted    = 0;
  int unsigned  mismatches    = 0;

  // Predictor copy of the range table, the event counters and the registers.
  logic                   tbl_valid [SLOTS];
  logic [PRIO_PORT_W-1:0] tbl_lo    [SLOTS];
  logic [PRIO_PORT_W-1:0] tbl_hi    [SLOTS];
  logic [POINT_W-1:0]     tbl_point [SLOTS];
  logic [COUNT_W-1:0]     evt_count [NUM_COUNTERS];
  logic                   dflt_en    = 1'b0;
  logic [POINT_W-1:0]     dflt_point = '0;

  assign req_type_i       = drv_item.req_type;
  assign entry_index_i    = drv_item.entry_index;
  assign entry_valid_i    = drv_item.entry_valid;
  assign range_start_i    = drv_item.range_start;
  assign range_end_i      = drv_item.range_end;
  assign entry_point_i    = drv_item.entry_point;
  assign header_present_i = drv_item.header_present;
  assign header_valid_i   = drv_item.header_valid;
  assign priority_value_i = drv_item.priority_value;
  assign shed_flags_i     = drv_item.shed_flags;

  priority_range_load_shed dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic void bump_event(int unsigned which);
    if (evt_count[which] != '1) evt_count[which] = evt_count[which] + COUNT_W'(1);
  endfunction

  function automatic shed_result_t predict_result(shed_item_t it);
    shed_result_t           r;
    logic [PRIO_PORT_W-1:0] lo;
    logic [PRIO_PORT_W-1:0] hi;
    logic [PRIO_PORT_W-1:0] v;
    logic                   hit;
    verdict_e               miss;
    int unsigned            k;
    r              = '0;
    r.verdict      = VERDICT_PASS;
    hit            = 1'b0;
    miss           = VERDICT_UNMATCHED;
    lo             = it.range_start & PRIO_MASK;
    hi             = it.range_end & PRIO_MASK;
    v              = it.priority_value & PRIO_MASK;
    if (it.req_type == REQ_WRITE) begin
      r.verdict = VERDICT_WRITE_OK;
      if (it.entry_index >= SLOTS) begin
        r.verdict = VERDICT_REFUSED;
      end else if (!it.entry_valid) begin
        tbl_valid[it.entry_index] = 1'b0;
      end else if (lo >= hi || it.entry_point >= POINTS) begin
        r.verdict = VERDICT_REFUSED;
      end else begin
        // The slot being rewritten does not count against itself.
        for (k = 0; k < SLOTS; k++)
          if (k != it.entry_index && tbl_valid[k] && lo < tbl_hi[k] && tbl_lo[k] < hi)
            r.verdict = VERDICT_REFUSED;
        if (r.verdict == VERDICT_WRITE_OK) begin
          tbl_valid[it.entry_index] = 1'b1;
          tbl_lo[it.entry_index]    = lo;
          tbl_hi[it.entry_index]    = hi;
          tbl_point[it.entry_index] = it.entry_point;
        end
      end
    end else begin
      bump_event(CNT_TOTAL);
      if (!it.header_present) begin
        bump_event(CNT_MISSING);
        miss = VERDICT_MISSING;
      end else if (!it.header_valid) begin
        bump_event(CNT_INVALID);
        miss = VERDICT_INVALID;
      end else begin
        for (k = 0; k < SLOTS && !hit; k++)
          if (tbl_valid[k] && tbl_lo[k] <= v && v < tbl_hi[k]) begin
            hit            = 1'b1;
            r.point_used   = tbl_point[k];
            r.matched_slot = IDX_W'(k);
          end
        if (!hit) bump_event(CNT_UNMATCHED);
      end
      if (!hit && dflt_en) begin
        hit            = 1'b1;
        r.point_used   = dflt_point;
        r.used_default = 1'b1;
      end
      if (!hit) begin
        r.verdict = miss;
      end else if (r.point_used < POINTS && it.shed_flags[r.point_used]) begin
        bump_event(CNT_SHED);
        r.verdict = VERDICT_SHED;
      end else begin
        bump_event(CNT_PASSED);
        r.verdict = VERDICT_PASS;
      end
    end
    r.request_count = evt_count[CNT_TOTAL];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic shed_item_t random_item();
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    return noise[$bits(shed_item_t)-1:0];
  endfunction

  // Unused fields of each transaction carry random noise.
  function automatic shed_item_t write_item(logic [IDX_W-1:0] idx, logic valid,
                                            logic [PRIO_PORT_W-1:0] lo,
                                            logic [PRIO_PORT_W-1:0] hi,
                                            logic [POINT_W-1:0] pt);
    shed_item_t it;
    it             = random_item();
    it.req_type    = REQ_WRITE;
    it.entry_index = idx;
    it.entry_valid = valid;
    it.range_start = lo;
    it.range_end   = hi;
    it.entry_point = pt;
    return it;
  endfunction

  function automatic shed_item_t request_item(logic present, logic hvalid,
                                              logic [PRIO_PORT_W-1:0] prio,
                                              logic [FLAGS_W-1:0] flags);
    shed_item_t it;
    it                = random_item();
    it.req_type       = REQ_CLASSIFY;
    it.header_present = present;
    it.header_valid   = hvalid;
    it.priority_value = prio;
    it.shed_flags     = flags;
    return it;
  endfunction

  task automatic queue_item(shed_item_t it);
    pending_items.insert(pending_items.size(), it);
    n_pushed++;
  endtask

  // Most writes land short ranges in a small window so requests often match
  // and writes often collide; others are inverted, random or near the top.
  task automatic queue_random_items(int unsigned count);
    shed_item_t             it;
    int unsigned            sel;
    logic [PRIO_PORT_W-1:0] lo;
    repeat (count) begin
      it  = random_item();
      sel = $urandom_range(99);
      lo  = PRIO_PORT_W'($urandom_range(LOCAL_SPAN));
      if (sel < 26) begin
        it.req_type    = REQ_WRITE;
        it.entry_valid = ($urandom_range(99) >= 15);
        sel            = $urandom_range(99);
        if (sel < 72) begin
          it.range_start = lo;
          it.range_end   = lo + PRIO_PORT_W'($urandom_range(400, 1));
        end else if (sel < 88 && sel >= 80) begin
          it.range_start = lo;
          it.range_end   = lo - PRIO_PORT_W'($urandom_range(lo));
        end else if (sel >= 88 && sel < 94) begin
          it.range_start = PRIO_MAX - PRIO_PORT_W'($urandom_range(3000, 1));
          it.range_end   = it.range_start +
                           PRIO_PORT_W'($urandom_range(PRIO_MAX - it.range_start, 1));
        end else if (sel >= 94) begin
          it.range_start = $urandom_range(1) ? '0 : lo;
          it.range_end   = PRIO_MAX;
        end
      end else begin
        it.req_type       = REQ_CLASSIFY;
        it.header_present = ($urandom_range(99) >= 8);
        it.header_valid   = ($urandom_range(99) >= 8);
        sel               = $urandom_range(99);
        if (sel < 70) begin
          it.priority_value = PRIO_PORT_W'($urandom_range(LOCAL_SPAN + 400));
        end else if (sel >= 85 && sel < 95) begin
          it.priority_value = PRIO_MAX - PRIO_PORT_W'($urandom_range(4000));
        end else if (sel >= 95) begin
          case ($urandom_range(2))
            0:       it.priority_value = '0;
            1:       it.priority_value = PRIO_MAX;
            default: it.priority_value = PRIO_MAX - PRIO_PORT_W'(1);
          endcase
        end
      end
      queue_item(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || n_accepted != n_pushed ||
           expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_DEFAULT_ENABLED) dflt_en = data[0];
    else dflt_point = data[POINT_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_segment(int unsigned send_pct, int unsigned recv_pct, logic en,
                             logic [POINT_W-1:0] pt);
    logic [CFG_DATA_W-1:0] enable_word;
    // Only bit 0 of the enable register matters; the upper bits are noise.
    enable_word    = CFG_DATA_W'($urandom);
    enable_word[0] = en;
    write_register(CFG_DEFAULT_ENABLED, enable_word);
    write_register(CFG_DEFAULT_POINT, pt);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    queue_random_items(SEGMENT_ITEMS);
    wait_drained();
  endtask

  // Driver: a new transaction is presented only once the previous one has
  // been taken, so a stalled payload never changes.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item   <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: checks each output transaction, then predicts each input one.
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, verdict", verdict_o, 0);
        end else begin
          oldest_result = expected_results.pop_front();
          if (verdict_o !== oldest_result.verdict)
            report_mismatch("verdict", verdict_o, oldest_result.verdict);
          if (point_used_o !== oldest_result.point_used)
            report_mismatch("point_used", point_used_o, oldest_result.point_used);
          if (used_default_o !== oldest_result.used_default)
            report_mismatch("used_default", used_default_o, oldest_result.used_default);
          if (matched_slot_o !== oldest_result.matched_slot)
            report_mismatch("matched_slot", matched_slot_o, oldest_result.matched_slot);
          if (request_count_o !== oldest_result.request_count)
            report_mismatch("request_count", request_count_o, oldest_result.request_count);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.insert(expected_results.size(), predict_result(drv_item));
        n_accepted++;
      end
    end
  end

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_lo[k]    = '0;
      tbl_hi[k]    = '0;
      tbl_point[k] = '0;
    end
    for (int k = 0; k < NUM_COUNTERS; k++) evt_count[k] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table with no default point: every request is rejected.
    queue_item(request_item(1'b0, 1'b1, 31'd100, 8'hFF));
    queue_item(request_item(1'b1, 1'b0, 31'd100, 8'hFF));
    queue_item(request_item(1'b1, 1'b1, 31'd100, 8'hFF));
    queue_item(write_item(3'd0, 1'b1, 31'd100, 31'd200, 3'd2));
    // Overlapping, adjacent and empty or inverted ranges.
    queue_item(write_item(3'd1, 1'b1, 31'd150, 31'd250, 3'd4));
    queue_item(write_item(3'd1, 1'b1, 31'd200, 31'd300, 3'd5));
    queue_item(write_item(3'd2, 1'b1, 31'd50, 31'd50, 3'd1));
    queue_item(write_item(3'd3, 1'b1, 31'd400, 31'd300, 3'd1));
    // Rewriting a slot is checked against the other slots only.
    queue_item(write_item(3'd0, 1'b1, 31'd90, 31'd200, 3'd3));
    queue_item(request_item(1'b1, 1'b1, 31'd90, 8'h08));
    queue_item(request_item(1'b1, 1'b1, 31'd199, 8'h00));
    queue_item(request_item(1'b1, 1'b1, 31'd200, 8'h20));
    queue_item(request_item(1'b1, 1'b1, 31'd300, 8'hFF));
    queue_item(write_item(3'd7, 1'b1, PRIO_MAX - 31'd15, PRIO_MAX, 3'd7));
    queue_item(write_item(3'd6, 1'b1, 31'd0, 31'd1, 3'd0));
    queue_item(request_item(1'b1, 1'b1, 31'd0, 8'hFF));
    queue_item(request_item(1'b1, 1'b1, PRIO_MAX - 31'd1, 8'h80));
    queue_item(request_item(1'b1, 1'b1, PRIO_MAX, 8'hFF));
    // A clear ignores its range fields, even an inverted range.
    queue_item(write_item(3'd0, 1'b0, 31'd500, 31'd7, 3'd6));
    queue_item(request_item(1'b1, 1'b1, 31'd150, 8'hFF));
    queue_item(write_item(3'd5, 1'b0, PRIO_MAX, 31'd0, 3'd7));
    queue_item(write_item(3'd5, 1'b1, 31'd0, PRIO_MAX, 3'd7));
    wait_drained();

    // Default point serves missing, invalid and unmatched requests.
    write_register(CFG_DEFAULT_ENABLED, CFG_DATA_W'(1));
    write_register(CFG_DEFAULT_POINT, CFG_DATA_W'(7));
    queue_item(request_item(1'b0, 1'b0, 31'd0, 8'h80));
    queue_item(request_item(1'b1, 1'b0, PRIO_MAX, 8'h00));
    queue_item(request_item(1'b1, 1'b1, 31'd150, 8'h7F));
    wait_drained();

    run_segment(0, 0, 1'b1, 3'd7);
    run_segment(55, 0, 1'b0, 3'd7);
    run_segment(0, 55, 1'b1, 3'd0);
    run_segment(29, 29, 1'b0, 3'd0);
    run_segment(0, 0, 1'b1, 3'd3);
    run_segment(55, 0, 1'b1, 3'd5);
    run_segment(0, 55, 1'b0, 3'd2);
    run_segment(29, 29, 1'b1, 3'd7);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("FAIL");
    $finish;
  end

endmodule

### priority_range_load_shed.f
+incdir+rtl
rtl/prls_pkg.sv
rtl/prls_ram.sv
rtl/prls_front.sv
rtl/prls_queue.sv
rtl/prls_back.sv
rtl/priority_range_load_shed.sv
verif/tb.sv
